[hdl/bcmp_pkg.sv]
`default_nettype none

package bcmp_pkg;

   localparam int unsigned DIV_STEPS = 64;

   localparam logic [20:0] PRESS_BASE = 21'd1048576;
   localparam logic signed [16:0] PRESS_SCALE = 17'sd3125;
   localparam logic signed [26:0] TFINE_OFFSET = 27'sd128000;
   localparam logic [63:0] PRESS_BIAS = 64'h0000_8000_0000_0000;

   localparam logic [1:0] CSR_TEMP_COEFFS = 2'd0;
   localparam logic [1:0] CSR_PRESS_LOW = 2'd1;
   localparam logic [1:0] CSR_PRESS_HIGH = 2'd2;
   localparam logic [1:0] CSR_PRESS_NINE = 2'd3;

   typedef struct packed {
      logic [15:0] c1;
      logic signed [15:0] c2;
      logic signed [15:0] c3;
      logic [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic [19:0] ap;
      logic signed [17:0] a;
      logic signed [16:0] d;
   } front_item_type;

   // partial products of a 64-bit word times a 17-bit signed constant, modulo 2^64
   typedef struct packed {
      logic signed [49:0] lo;
      logic [31:0] hi;
   } pp_type;

   // partial products of a 64 by 64 product, modulo 2^64
   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] mid;
   } pp64_type;

   function automatic pp_type pp17(input logic [63:0] x, input logic signed [16:0] c);
      pp_type r;
      r.lo = $signed({1'b0, x[31:0]}) * c;
      r.hi = 32'($signed({1'b0, x[63:32]}) * c);
      return r;
   endfunction

   function automatic logic [63:0] pp_sum(input pp_type p);
      return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'b0};
   endfunction

   function automatic pp64_type pp64(input logic [63:0] a, input logic [63:0] b);
      pp64_type r;
      r.ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
      r.mid = 32'(a[31:0] * b[63:32]) + 32'(a[63:32] * b[31:0]);
      return r;
   endfunction

   function automatic logic [63:0] pp64_sum(input pp64_type p);
      return p.ll + {p.mid, 32'b0};
   endfunction

endpackage

`default_nettype wire

[hdl/bcmp_front.sv]
`default_nettype none

module bcmp_front
   import bcmp_pkg::*;
(
   input  wire logic           push,
   input  wire logic [19:0]    raw_pressure,
   input  wire logic [19:0]    raw_temperature,
   input  wire coeff_type      coeff,
   input  wire logic           queue_full,
   output logic                full,
   output logic                wr_en,
   output front_item_type      wr_item
);

   logic [17:0] a_w;
   logic [16:0] d_w;

   assign a_w = {1'b0, raw_temperature[19:3]} - {1'b0, coeff.c1, 1'b0};
   assign d_w = {1'b0, raw_temperature[19:4]} - {1'b0, coeff.c1};

   assign full = queue_full;
   assign wr_en = push && !queue_full;

   always_comb begin
      wr_item.ap = raw_pressure;
      wr_item.a = $signed(a_w);
      wr_item.d = $signed(d_w);
   end

endmodule

`default_nettype wire

[hdl/bcmp_queue.sv]
`default_nettype none

module bcmp_queue
   import bcmp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           wr_en,
   input  wire front_item_type wr_item,
   input  wire logic           rd_en,
   output front_item_type      rd_item,
   output logic                full,
   output logic                empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   front_item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

[hdl/bcmp_back.sv]
`default_nettype none

module bcmp_back
   import bcmp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire coeff_type      coeff,
   input  wire logic           queue_empty,
   input  wire front_item_type queue_item,
   output logic                queue_rd,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output logic [15:0]         rsp_temperature_centi,
   output logic [31:0]         rsp_pressure_q24_8,
   output logic                rsp_pressure_invalid
);

   localparam int unsigned STAGES = 11 + DIV_STEPS + 1 + 8;

   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] n;
      logic [30:0] ub;
      logic neg;
      logic zero;
      logic [15:0] tc;
   } div_type;

   typedef struct packed {
      logic [15:0] tc;
      logic zero;
   } tag_type;

   function automatic div_type div_step(input div_type s);
      div_type r;
      logic [31:0] shifted;
      logic [32:0] diff;
      r = s;
      shifted = {s.rem, s.n[63]};
      diff = {1'b0, shifted} - {2'b0, s.ub};
      r.n = {s.n[62:0], !diff[32]};
      r.rem = diff[32] ? shifted[30:0] : diff[30:0];
      return r;
   endfunction

   logic signed [15:0] c2, c3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign c2 = coeff.c2;
   assign c3 = coeff.c3;
   assign p2 = coeff.p2;
   assign p3 = coeff.p3;
   assign p4 = coeff.p4;
   assign p5 = coeff.p5;
   assign p6 = coeff.p6;
   assign p7 = coeff.p7;
   assign p8 = coeff.p8;
   assign p9 = coeff.p9;

   logic adv;
   logic [STAGES-1:0] vld_ff;

   assign adv = !vld_ff[STAGES-1] || rsp_pop;
   assign queue_rd = adv && !queue_empty;
   assign rsp_empty = !vld_ff[STAGES-1];

   logic signed [33:0] m1_ff, m1_in, dd_ff, dd_in;
   logic signed [22:0] v1t_ff, v1t_in;
   logic signed [37:0] m2_ff, m2_in;
   logic signed [21:0] v2a;
   logic signed [25:0] tf_ff, tf_in;
   logic signed [28:0] t5;
   logic signed [20:0] tcw;
   logic [15:0] tc4_in;
   logic signed [26:0] e_ff, e_in;
   logic signed [53:0] ee_ff, ee_in;
   logic signed [42:0] ep5_ff, ep5_in, ep2_ff, ep2_in;
   pp_type pp6_ff, pp6_in, pp3_ff, pp3_in;
   logic signed [42:0] ep5_6_ff, ep2_6_ff, ep5_7_ff, ep2_7_ff;
   logic [63:0] x6_ff, x3_ff;
   logic signed [63:0] x3s;
   logic [63:0] v2_ff, v2_in, v1a_ff, v1a_in;
   logic [63:0] w_ff, num0_ff, num0_in;
   logic [20:0] pb;
   pp_type ppw_ff, ppn_ff;
   logic signed [63:0] wsum;
   logic signed [30:0] dvs_ff, dvs_in;
   logic [63:0] num_ff;
   logic [19:0] ap1_ff, ap2_ff, ap3_ff, ap4_ff, ap5_ff, ap6_ff, ap7_ff, ap8_ff;
   logic [15:0] tc4_ff, tc5_ff, tc6_ff, tc7_ff, tc8_ff, tc9_ff, tc10_ff, tc11_ff;

   div_type div_ff [DIV_STEPS+1];
   div_type div_in [DIV_STEPS+1];

   logic [63:0] q1_ff, q1_in, q2_ff, q3_ff, q4_ff, q5_ff;
   logic signed [63:0] ps2_ff, ps2_in, ps3_ff;
   pp_type pp9_ff, pp8_ff;
   logic [63:0] t_ff;
   logic signed [63:0] y8_3_ff, y8_3_in, y8_4_ff, y8_5_ff;
   pp64_type ppt_ff;
   logic signed [63:0] y9_ff, y9_in;
   logic [63:0] s_ff;
   logic signed [63:0] ssh;
   logic [63:0] r_ff, r_in;
   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff, tag7_ff;
   logic [31:0] pout_in;
   logic [63:0] n_abs, num_abs;

   always_comb begin
      m1_in = queue_item.a * c2;
      dd_in = queue_item.d * queue_item.d;
      v1t_in = 23'(m1_ff >>> 11);
      v2a = 22'(dd_ff >>> 12);
      m2_in = v2a * c3;
      tf_in = 26'(v1t_ff) + 26'(m2_ff >>> 14);
      t5 = tf_ff * 29'sd5 + 29'sd128;
      tcw = 21'(t5 >>> 8);
      if (tcw < -21'sd32768) begin
         tc4_in = 16'h8000;
      end else if (tcw > 21'sd32767) begin
         tc4_in = 16'h7FFF;
      end else begin
         tc4_in = tcw[15:0];
      end
      e_in = tf_ff - TFINE_OFFSET;
      ee_in = e_ff * e_ff;
      ep5_in = e_ff * p5;
      ep2_in = e_ff * p2;
      pp6_in = pp17({{10{ee_ff[53]}}, ee_ff}, {p6[15], p6});
      pp3_in = pp17({{10{ee_ff[53]}}, ee_ff}, {p3[15], p3});
      x3s = $signed(x3_ff) >>> 8;
      v2_in = x6_ff + ({{21{ep5_7_ff[42]}}, ep5_7_ff} << 17) + ({{48{p4[15]}}, p4} << 35);
      v1a_in = x3s + ({{21{ep2_7_ff[42]}}, ep2_7_ff} << 12);
      pb = PRESS_BASE - {1'b0, ap8_ff};
      num0_in = {12'b0, pb, 31'b0} - v2_ff;
      wsum = pp_sum(ppw_ff);
      dvs_in = 31'(wsum >>> 33);
   end

   always_comb begin
      num_abs = num_ff[63] ? -num_ff : num_ff;
      n_abs = {33'b0, dvs_ff[30] ? -dvs_ff : dvs_ff};
      div_in[0].rem = '0;
      div_in[0].n = num_abs;
      div_in[0].ub = n_abs[30:0];
      div_in[0].neg = num_ff[63] ^ dvs_ff[30];
      div_in[0].zero = (dvs_ff == '0);
      div_in[0].tc = tc11_ff;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   always_comb begin
      q1_in = div_ff[DIV_STEPS].neg ? -div_ff[DIV_STEPS].n : div_ff[DIV_STEPS].n;
      ps2_in = $signed(q1_ff) >>> 13;
      y8_3_in = $signed(pp_sum(pp8_ff)) >>> 19;
      y9_in = $signed(pp64_sum(ppt_ff)) >>> 25;
      ssh = $signed(s_ff) >>> 8;
      r_in = ssh + ({{48{p7[15]}}, p7} << 4);
      if (r_ff[63]) begin
         pout_in = '0;
      end else if (r_ff[62:32] != '0) begin
         pout_in = '1;
      end else begin
         pout_in = r_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], !queue_empty};
      end
      if (adv) begin
         m1_ff <= m1_in;
         dd_ff <= dd_in;
         ap1_ff <= queue_item.ap;
         v1t_ff <= v1t_in;
         m2_ff <= m2_in;
         ap2_ff <= ap1_ff;
         tf_ff <= tf_in;
         ap3_ff <= ap2_ff;
         tc4_ff <= tc4_in;
         e_ff <= e_in;
         ap4_ff <= ap3_ff;
         ee_ff <= ee_in;
         ep5_ff <= ep5_in;
         ep2_ff <= ep2_in;
         tc5_ff <= tc4_ff;
         ap5_ff <= ap4_ff;
         pp6_ff <= pp6_in;
         pp3_ff <= pp3_in;
         ep5_6_ff <= ep5_ff;
         ep2_6_ff <= ep2_ff;
         tc6_ff <= tc5_ff;
         ap6_ff <= ap5_ff;
         x6_ff <= pp_sum(pp6_ff);
         x3_ff <= pp_sum(pp3_ff);
         ep5_7_ff <= ep5_6_ff;
         ep2_7_ff <= ep2_6_ff;
         tc7_ff <= tc6_ff;
         ap7_ff <= ap6_ff;
         v2_ff <= v2_in;
         v1a_ff <= v1a_in;
         tc8_ff <= tc7_ff;
         ap8_ff <= ap7_ff;
         w_ff <= v1a_ff + PRESS_BIAS;
         num0_ff <= num0_in;
         tc9_ff <= tc8_ff;
         ppw_ff <= pp17(w_ff, {1'b0, coeff.p1});
         ppn_ff <= pp17(num0_ff, PRESS_SCALE);
         tc10_ff <= tc9_ff;
         dvs_ff <= dvs_in;
         num_ff <= pp_sum(ppn_ff);
         tc11_ff <= tc10_ff;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_ff[k] <= div_in[k];
         end
         q1_ff <= q1_in;
         tag1_ff <= '{tc: div_ff[DIV_STEPS].tc, zero: div_ff[DIV_STEPS].zero};
         q2_ff <= q1_ff;
         ps2_ff <= ps2_in;
         pp9_ff <= pp17(ps2_in, {p9[15], p9});
         pp8_ff <= pp17(q1_ff, {p8[15], p8});
         tag2_ff <= tag1_ff;
         q3_ff <= q2_ff;
         ps3_ff <= ps2_ff;
         t_ff <= pp_sum(pp9_ff);
         y8_3_ff <= y8_3_in;
         tag3_ff <= tag2_ff;
         q4_ff <= q3_ff;
         y8_4_ff <= y8_3_ff;
         ppt_ff <= pp64(t_ff, ps3_ff);
         tag4_ff <= tag3_ff;
         q5_ff <= q4_ff;
         y8_5_ff <= y8_4_ff;
         y9_ff <= y9_in;
         tag5_ff <= tag4_ff;
         s_ff <= q5_ff + y9_ff + y8_5_ff;
         tag6_ff <= tag5_ff;
         r_ff <= r_in;
         tag7_ff <= tag6_ff;
         rsp_temperature_centi <= tag7_ff.tc;
         rsp_pressure_q24_8 <= tag7_ff.zero ? '0 : pout_in;
         rsp_pressure_invalid <= tag7_ff.zero;
      end
   end

endmodule

`default_nettype wire

[hdl/baro_temp_pressure_compensation_core.sv]
// Barometric temperature and pressure compensation core.
// Input channel (req_): push a pair of raw 20-bit pressure and temperature
// conversions while req_full is low; a transaction completes when req_push
// is high and req_full low.
// Result channel (rsp_): while rsp_empty is low the oldest result stands on
// rsp_temperature_centi, rsp_pressure_q24_8 and rsp_pressure_invalid; raise
// rsp_pop to take it.
// Configuration channel (csr_): write the four coefficient registers by
// index; csr_ready is always high. Write only while the core is idle.
// Throughput is one transaction per cycle while the receiver keeps up. The
// result passes through the queue, eleven multiply stages, the 64-step
// restoring divider pipeline for the pressure quotient, and eight stages
// of correction, clamp and output.
// Reset clears the queue, the pipeline valid bits and all coefficients.
// When the receiver stalls, the whole back pipeline holds; the input queue
// keeps accepting until it fills, then req_full rises.
`default_nettype none

module baro_temp_pressure_compensation_core
   import bcmp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [19:0] req_raw_pressure,
   input  wire logic [19:0] req_raw_temperature,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [15:0]      rsp_temperature_centi,
   output logic [31:0]      rsp_pressure_q24_8,
   output logic             rsp_pressure_invalid,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_nine_ff;
   coeff_type coeff;

   logic queue_full, queue_empty, queue_wr, queue_rd;
   front_item_type wr_item, rd_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff <= '0;
         press_high_ff <= '0;
         press_nine_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEMP_COEFFS: temp_coeffs_ff <= csr_data[47:0];
            CSR_PRESS_LOW: press_low_ff <= csr_data;
            CSR_PRESS_HIGH: press_high_ff <= csr_data;
            CSR_PRESS_NINE: press_nine_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coeff.c1 = temp_coeffs_ff[15:0];
      coeff.c2 = temp_coeffs_ff[31:16];
      coeff.c3 = temp_coeffs_ff[47:32];
      coeff.p1 = press_low_ff[15:0];
      coeff.p2 = press_low_ff[31:16];
      coeff.p3 = press_low_ff[47:32];
      coeff.p4 = press_low_ff[63:48];
      coeff.p5 = press_high_ff[15:0];
      coeff.p6 = press_high_ff[31:16];
      coeff.p7 = press_high_ff[47:32];
      coeff.p8 = press_high_ff[63:48];
      coeff.p9 = press_nine_ff;
   end

   bcmp_front u_front (
      .push            (req_push),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .coeff           (coeff),
      .queue_full      (queue_full),
      .full            (req_full),
      .wr_en           (queue_wr),
      .wr_item         (wr_item)
   );

   bcmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_wr),
      .wr_item (wr_item),
      .rd_en   (queue_rd),
      .rd_item (rd_item),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   bcmp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .coeff                 (coeff),
      .queue_empty           (queue_empty),
      .queue_item            (rd_item),
      .queue_rd              (queue_rd),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_pressure_invalid  (rsp_pressure_invalid)
   );

endmodule

`default_nettype wire
